// ===== hdl/wpi_pkg.sv =====
`default_nettype none
package wpi_pkg;

    localparam int POS_W  = 34;
    localparam int TIME_W = 32;
    localparam int VEL_W  = 40;
    localparam int STAT_W = 3;

    typedef enum logic [STAT_W-1:0] {
        ST_INTERP = 3'd0,
        ST_FIRST  = 3'd1,
        ST_LAST   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_WRITE  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_SCAN_CHK,
        S_FRAC,
        S_DIV,
        S_MUL,
        S_OUT
    } fsm_t;

    // one waypoint entry
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [TIME_W-1:0]       t;
    } wp_t;

    // divider control between sequencer and divider
    typedef struct packed {
        logic              start;
        logic [63:0]       num;
        logic [TIME_W-1:0] den;
    } div_req_t;

endpackage
`default_nettype wire

// ===== hdl/wpi_table.sv =====
`default_nettype none
module wpi_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic            aclk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire wpi_pkg::wp_t    wdata,
    input  wire logic [AW-1:0]   raddr,
    output wpi_pkg::wp_t         rdata
);
    wpi_pkg::wp_t mem [DEPTH];

    // synchronous write, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/wpi_div.sv =====
`default_nettype none
module wpi_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire wpi_pkg::div_req_t          req,
    output logic [63:0]                     quo,
    output logic                            done
);
    logic [63:0]              q_reg, q_next;
    logic [wpi_pkg::TIME_W:0] r_reg, r_next;
    logic [wpi_pkg::TIME_W-1:0] d_reg;
    logic [6:0]               cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg;
    logic [wpi_pkg::TIME_W+1:0] trial;

    // restoring division, one quotient bit a cycle
    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg, q_reg[63]} - {2'b00, d_reg};
        if (req.start) begin
            q_next    = req.num;
            r_next    = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[wpi_pkg::TIME_W+1]) begin
                r_next = trial[wpi_pkg::TIME_W:0];
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = {r_reg[wpi_pkg::TIME_W-1:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    // done pulses once the last quotient bit is in q_reg
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= busy_reg && (cnt_reg == 7'd1);
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (req.start) begin
            d_reg <= req.den;
        end
    end

    assign quo  = q_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

// ===== hdl/waypoint_path_interpolator.sv =====
// channel   | dir | tdata fields (low bit first)                  | tuser
// s_axis    | in  | entry_index, pos_x, pos_y, pos_z, time_ms     | opcode
// m_axis    | out | out_x, out_y, out_z, vel_x, vel_y, vel_z      | status
// cfg       | in  | waypoint_count via cfg_wr_en / cfg_wr_data    | -
//
// result valid after accept via S_OUT: write or empty table directly, held first via
// S_RD_FIRST, S_CHK_FIRST, held last also S_CHK_LAST; interpolated sample: one table
// read per scanned waypoint, then fraction and three velocity divisions on one divider
// reset clears the sequencer, the output valid and waypoint_count; table stays undefined
// the result waits in the output register; a new item is taken in the cycle after it left
`default_nettype none
module waypoint_path_interpolator #(
    parameter int MAX_WAYPOINTS = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [4:0]    cfg_wr_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // entry_index[3:0], pos_x[37:4], pos_y[71:38], pos_z[105:72], time_ms[137:106]
    input  wire logic [143:0]  s_axis_tdata,
    // opcode
    input  wire logic [0:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // out_x[33:0], out_y[67:34], out_z[101:68], vel_x[141:102],
    // vel_y[181:142], vel_z[221:182]
    output logic [223:0]       m_axis_tdata,
    // status
    output logic [2:0]         m_axis_tuser
);
    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam int PW = wpi_pkg::POS_W;
    localparam int VW = wpi_pkg::VEL_W;
    localparam int TW = wpi_pkg::TIME_W;
    localparam logic [63:0] VMAXP = (64'd1 << (VW - 1)) - 64'd1;
    localparam logic [63:0] VMAXN = 64'd1 << (VW - 1);

    // input fields
    logic [3:0]          in_idx;
    wpi_pkg::wp_t        in_wp;
    assign in_idx  = s_axis_tdata[3:0];
    assign in_wp.x = s_axis_tdata[37:4];
    assign in_wp.y = s_axis_tdata[71:38];
    assign in_wp.z = s_axis_tdata[105:72];
    assign in_wp.t = s_axis_tdata[137:106];

    logic [4:0] count_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    // effective count, saturated
    logic [CW-1:0] n_eff;
    assign n_eff = ({27'd0, count_reg} > MAX_WAYPOINTS) ? CW'(MAX_WAYPOINTS)
                                                        : CW'(count_reg);

    wpi_pkg::fsm_t state_reg, state_next;
    logic          accept;
    logic          we;
    logic [AW-1:0] raddr;
    wpi_pkg::wp_t  rdata;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign we     = accept && !s_axis_tuser[0] && ({28'd0, in_idx} < MAX_WAYPOINTS);

    wpi_table #(.DEPTH(MAX_WAYPOINTS), .AW(AW)) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (AW'(in_idx)),
        .wdata (in_wp),
        .raddr (raddr),
        .rdata (rdata)
    );

    wpi_pkg::div_req_t dreq;
    logic [63:0]       dquo;
    logic              ddone;
    wpi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .quo     (dquo),
        .done    (ddone)
    );

    // working registers
    logic [TW-1:0]          qt_reg;
    logic [CW-1:0]          i_reg, i_next;
    wpi_pkg::wp_t           a_reg, b_reg;
    logic [1:0]             ax_reg, ax_next;
    logic [FRACTION_BITS:0] r_reg;
    logic                   fr_reg, fr_next;
    logic signed [PW:0]     d_sel;
    logic signed [PW-1:0]   a_sel;
    logic [PW:0]            mag;
    logic                   neg_reg;
    logic signed [PW+FRACTION_BITS+2:0] prod_reg;
    logic [PW-1:0]          ox_reg [3];
    logic [VW-1:0]          vx_reg [3];
    wpi_pkg::status_t       st_reg, st_next;
    logic                   ov_reg;
    logic                   seg_hit;
    logic [63:0]            vq;
    logic [VW-1:0]          vsat;
    logic signed [PW+FRACTION_BITS+2:0] bias;
    logic [TW-1:0]          dt;

    assign dt = b_reg.t - a_reg.t;

    // segment found at the scanned entry; the last entry always closes a segment
    assign seg_hit = (qt_reg <= rdata.t) || (i_reg == n_eff - CW'(1));

    // axis selection for the shared arithmetic
    always_comb begin
        unique case (ax_reg)
            2'd0: begin
                d_sel = {b_reg.x[PW-1], b_reg.x} - {a_reg.x[PW-1], a_reg.x};
                a_sel = a_reg.x;
            end
            2'd1: begin
                d_sel = {b_reg.y[PW-1], b_reg.y} - {a_reg.y[PW-1], a_reg.y};
                a_sel = a_reg.y;
            end
            default: begin
                d_sel = {b_reg.z[PW-1], b_reg.z} - {a_reg.z[PW-1], a_reg.z};
                a_sel = a_reg.z;
            end
        endcase
        mag = d_sel[PW] ? (PW+1)'(0) - d_sel : d_sel;
    end

    // velocity saturation
    always_comb begin
        vq = dquo;
        if (neg_reg) begin
            vsat = (vq > VMAXN) ? VMAXN[VW-1:0] : VW'(64'd0 - vq);
        end else begin
            vsat = (vq > VMAXP) ? VMAXP[VW-1:0] : vq[VW-1:0];
        end
    end

    assign bias = (PW+FRACTION_BITS+3)'(1) <<< (FRACTION_BITS - 1);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        i_next          = i_reg;
        ax_next         = ax_reg;
        fr_next         = fr_reg;
        st_next         = st_reg;
        raddr           = '0;
        dreq.start      = 1'b0;
        dreq.num        = '0;
        dreq.den        = dt;
        s_axis_tready   = 1'b0;
        unique case (state_reg)
            wpi_pkg::S_IDLE: begin
                s_axis_tready = !ov_reg;
                if (accept) begin
                    if (!s_axis_tuser[0]) begin
                        st_next    = wpi_pkg::ST_WRITE;
                        state_next = wpi_pkg::S_OUT;
                    end else if (n_eff == '0) begin
                        st_next    = wpi_pkg::ST_EMPTY;
                        state_next = wpi_pkg::S_OUT;
                    end else begin
                        state_next = wpi_pkg::S_RD_FIRST;
                    end
                end
            end
            wpi_pkg::S_RD_FIRST: begin
                raddr      = '0;
                state_next = wpi_pkg::S_CHK_FIRST;
            end
            wpi_pkg::S_CHK_FIRST: begin
                raddr = AW'(n_eff - CW'(1));
                if (qt_reg <= rdata.t) begin
                    st_next    = wpi_pkg::ST_FIRST;
                    state_next = wpi_pkg::S_OUT;
                end else begin
                    state_next = wpi_pkg::S_CHK_LAST;
                end
            end
            wpi_pkg::S_CHK_LAST: begin
                raddr = AW'(1);
                if (qt_reg >= rdata.t) begin
                    st_next    = wpi_pkg::ST_LAST;
                    state_next = wpi_pkg::S_OUT;
                end else begin
                    i_next     = CW'(1);
                    state_next = wpi_pkg::S_SCAN_CHK;
                end
            end
            wpi_pkg::S_SCAN_CHK: begin
                if (seg_hit) begin
                    state_next = wpi_pkg::S_FRAC;
                end else begin
                    i_next = i_reg + CW'(1);
                    raddr  = AW'(i_reg + CW'(1));
                end
            end
            wpi_pkg::S_FRAC: begin
                // fraction division
                st_next    = wpi_pkg::ST_INTERP;
                fr_next    = 1'b1;
                dreq.start = 1'b1;
                dreq.num   = 64'(qt_reg - a_reg.t) << FRACTION_BITS;
                dreq.den   = dt;
                state_next = wpi_pkg::S_DIV;
            end
            wpi_pkg::S_DIV: begin
                if (ddone) begin
                    if (fr_reg) begin
                        fr_next    = 1'b0;
                        ax_next    = 2'd0;
                        state_next = wpi_pkg::S_MUL;
                    end else if (ax_reg == 2'd2) begin
                        state_next = wpi_pkg::S_OUT;
                    end else begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = wpi_pkg::S_MUL;
                    end
                end
            end
            wpi_pkg::S_MUL: begin
                // product registered; velocity division for this axis
                dreq.start = 1'b1;
                dreq.num   = 64'(mag) * 64'd1000;
                dreq.den   = dt;
                state_next = wpi_pkg::S_DIV;
            end
            wpi_pkg::S_OUT: begin
                state_next = wpi_pkg::S_IDLE;
            end
            default: state_next = wpi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wpi_pkg::S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == wpi_pkg::S_OUT) begin
                ov_reg <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                ov_reg <= 1'b0;
            end
        end
        i_reg  <= i_next;
        ax_reg <= ax_next;
        fr_reg <= fr_next;
        st_reg <= st_next;
        if (accept) begin
            qt_reg <= in_wp.t;
        end
        // segment endpoints: a trails the scan by one entry, b is the hit or the held entry
        if (state_reg == wpi_pkg::S_CHK_FIRST) begin
            a_reg <= rdata;
            b_reg <= rdata;
        end
        if (state_reg == wpi_pkg::S_CHK_LAST) begin
            b_reg <= rdata;
        end
        if (state_reg == wpi_pkg::S_SCAN_CHK) begin
            if (seg_hit) begin
                b_reg <= rdata;
            end else begin
                a_reg <= rdata;
            end
        end
        // fraction result
        if (state_reg == wpi_pkg::S_DIV && ddone && fr_reg) begin
            r_reg <= dquo[FRACTION_BITS:0];
        end
        // interpolation product and rounding, then velocity
        if (state_reg == wpi_pkg::S_MUL) begin
            prod_reg <= (PW+FRACTION_BITS+3)'(d_sel)
                        * $signed({1'b0, r_reg}) + bias;
            neg_reg  <= d_sel[PW];
        end
        if (state_reg == wpi_pkg::S_DIV && ddone && !fr_reg) begin
            ox_reg[ax_reg] <= PW'(a_sel + PW'(prod_reg >>> FRACTION_BITS));
            vx_reg[ax_reg] <= vsat;
        end
        if (state_reg == wpi_pkg::S_OUT) begin
            m_axis_tuser <= st_reg;
            if (st_reg == wpi_pkg::ST_INTERP) begin
                m_axis_tdata <= {2'b00, vx_reg[2], vx_reg[1], vx_reg[0],
                                 ox_reg[2], ox_reg[1], ox_reg[0]};
            end else if (st_reg == wpi_pkg::ST_FIRST || st_reg == wpi_pkg::ST_LAST) begin
                m_axis_tdata <= {2'b00, {(3*VW){1'b0}}, b_reg.z, b_reg.y, b_reg.x};
            end else begin
                m_axis_tdata <= '0;
            end
        end
    end

    assign m_axis_tvalid = ov_reg;

    // output holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed under stall");
    // no new item while a result waits
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("item taken while result pending");
    // divider only starts from the fraction or product state
    a_div: assert property (@(posedge aclk) disable iff (!aresetn)
        dreq.start |-> (state_reg == wpi_pkg::S_FRAC || state_reg == wpi_pkg::S_MUL))
        else $error("stray divider start");
    // a pending result means the sequencer is idle
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (state_reg == wpi_pkg::S_IDLE))
        else $error("sequencer busy with result pending");
endmodule
`default_nettype wire
